/* src/tbsf_pkg.sv */
package tbsf_pkg;

  // shared multiplier: signed operands, full-width registered product
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 60;
  localparam int QW     = 24;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // constant dividers: q0 = (x * recip) >> shift, then one remainder fix-up
  // gyro scaling 65536/1800 is folded to 8192/225
  localparam logic [31:0] GYRO_DIV    = 32'd225;
  localparam logic [31:0] GYRO_RECIP  = 32'd1221679586;
  localparam int          GYRO_SHIFT  = 38;
  localparam logic [31:0] LEAK_DIV    = 32'd1000;
  localparam logic [31:0] LEAK_RECIP  = 32'd2199023255;
  localparam int          LEAK_SHIFT  = 41;
  localparam logic [31:0] BLEND_DIV   = 32'd10;
  localparam logic [31:0] BLEND_RECIP = 32'd429496729;
  localparam int          BLEND_SHIFT = 32;
  localparam logic [31:0] LEFT_DIV    = 32'd5;
  localparam logic [31:0] LEFT_RECIP  = 32'd858993459;
  localparam int          LEFT_SHIFT  = 32;

  // 45.0 in q15.16
  localparam logic signed [31:0] DIST_BOUND = 32'sd2949120;

endpackage

/* src/tbsf_mul.sv */
module tbsf_mul (
  input  logic                               clk,
  input  tbsf_pkg::mul_req_t                 req,
  output logic signed [tbsf_pkg::PROD_W-1:0] prod
);
  import tbsf_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= $signed(req.a) * $signed(req.b);
    end
  end

  assign prod = prod_r;

endmodule

/* src/tilt_balance_state_feedback.sv */
// Tilt-balance state feedback: one beat per control tick carries the raw pitch
// gyro sample and the two encoder count deltas; one beat comes back with the
// right and left drive commands. Internally the rate, tilt, wheel speeds and
// distances are signed q15.16 and the gains q7.16. Every product and every
// constant division (by 1800, 1000, 10 and 5, done as reciprocal multiply plus
// one remainder fix-up) goes through a single 33x33 multiplier under a
// 20-step sequencer, so the input accepts a new tick only after the last step
// of the current one. A finished result is held in the output register until
// taken; the next tick can be accepted and worked on meanwhile, and only its
// last step waits for that register to free up. Registers sit on the APB port
// at byte offsets 0x00 gyro_zero, 0x04 angle_gain, 0x08 rate_gain,
// 0x0c distance_gain, 0x10 speed_gain, 0x14 encoder_scale, 0x18 tick_seconds,
// 0x1c speed_limit, and should be written while no tick is in flight.
module tilt_balance_state_feedback (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // gyro_rate_raw, left_counts, right_counts
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // right_drive, left_drive
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tbsf_pkg::*;

  // sequencer state
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // sequencer steps
  localparam logic [4:0] SP_GYRO_MUL = 5'd0;   // |diff|<<13 * recip(225)
  localparam logic [4:0] SP_GYRO_FIX = 5'd1;   // q0 * 225
  localparam logic [4:0] SP_GYRO_END = 5'd2;   // rate out, left counts * scale
  localparam logic [4:0] SP_SPD_L    = 5'd3;   // left speed, right counts * scale
  localparam logic [4:0] SP_SPD_R    = 5'd4;   // right speed, rate * tick
  localparam logic [4:0] SP_TILT_INT = 5'd5;   // integrate tilt and distances
  localparam logic [4:0] SP_ACC_SPD  = 5'd6;   // speed term in, distance term out
  localparam logic [4:0] SP_LEAK_MUL = 5'd7;   // (|tilt|+999) * recip(1000)
  localparam logic [4:0] SP_LEAK_FIX = 5'd8;
  localparam logic [4:0] SP_LEAK_END = 5'd9;   // leaked tilt, rate term out
  localparam logic [4:0] SP_ACC_RATE = 5'd10;  // angle term out
  localparam logic [4:0] SP_ACC_ANG  = 5'd11;
  localparam logic [4:0] SP_SUM      = 5'd12;  // weighted sum, q16 truncate
  localparam logic [4:0] SP_BLEND    = 5'd13;  // 0.1 old + 0.9 new
  localparam logic [4:0] SP_BL_MUL   = 5'd14;
  localparam logic [4:0] SP_BL_FIX   = 5'd15;
  localparam logic [4:0] SP_BL_END   = 5'd16;  // clamp, right drive
  localparam logic [4:0] SP_LEFT_MUL = 5'd17;  // 7*|right| / 5
  localparam logic [4:0] SP_LEFT_FIX = 5'd18;
  localparam logic [4:0] SP_LEFT_END = 5'd19;  // left drive, load output

  // register map
  localparam logic [2:0] REG_GYRO_ZERO     = 3'd0;
  localparam logic [2:0] REG_ANGLE_GAIN    = 3'd1;
  localparam logic [2:0] REG_RATE_GAIN     = 3'd2;
  localparam logic [2:0] REG_DISTANCE_GAIN = 3'd3;
  localparam logic [2:0] REG_SPEED_GAIN    = 3'd4;
  localparam logic [2:0] REG_ENCODER_SCALE = 3'd5;
  localparam logic [2:0] REG_TICK_SECONDS  = 3'd6;
  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd7;

  // saturate to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic [PROD_W-1:0] v);
    logic [31:0] res;
    if (&v[PROD_W-1:31] || ~|v[PROD_W-1:31]) begin
      res = v[31:0];
    end else if (v[PROD_W-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7fff_ffff;
    end
    return res;
  endfunction

  function automatic logic [PROD_W-1:0] sx32(input logic [31:0] v);
    return {{(PROD_W-32){v[31]}}, v};
  endfunction

  // divide by 2^16, rounding toward zero
  function automatic logic [PROD_W-1:0] q16_trunc(input logic [PROD_W-1:0] v);
    logic [PROD_W-1:0] adj;
    adj = v + (v[PROD_W-1] ? PROD_W'(65535) : '0);
    return {{16{adj[PROD_W-1]}}, adj[PROD_W-1:16]};
  endfunction

  // configuration registers
  logic [15:0] gyro_zero_r;
  logic [23:0] angle_gain_r;
  logic [23:0] rate_gain_r;
  logic [23:0] distance_gain_r;
  logic [23:0] speed_gain_r;
  logic [23:0] encoder_scale_r;
  logic [15:0] tick_seconds_r;
  logic [14:0] speed_limit_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // sequencer and datapath registers
  logic        state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [15:0] raw_r, raw_nxt;
  logic [15:0] lcnt_r, lcnt_nxt;
  logic [15:0] rcnt_r, rcnt_nxt;
  logic [31:0] x_r, x_nxt;            // dividend of the running division
  logic [QW-1:0] q_r, q_nxt;          // estimated quotient
  logic        rsign_r, rsign_nxt;
  logic        tsign_r, tsign_nxt;
  logic        bsign_r, bsign_nxt;
  logic [22:0] rate_r, rate_nxt;
  logic [31:0] speed_l_r, speed_l_nxt;
  logic [31:0] speed_r_r, speed_r_nxt;
  logic [31:0] tilt_r, tilt_nxt;
  logic [31:0] dist_l_r, dist_l_nxt;
  logic [31:0] dist_r_r, dist_r_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [15:0] right_hold_r, right_hold_nxt;  // right drive until the beat loads
  logic [15:0] right_r, right_nxt;
  logic [15:0] left_r, left_nxt;
  logic        out_valid_r, out_valid_nxt;

  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;

  // datapath helpers
  logic signed [16:0] gyro_diff;
  logic [15:0]        gyro_mag;
  logic [31:0]        rem;
  logic [31:0]        div_cur;
  logic [QW-1:0]      fixed_q;
  logic [22:0]        rate_val;
  logic [32:0]        spd_sum, spd_adj, dst_sum, dst_adj;
  logic [31:0]        mean_s, mean_d;
  logic [31:0]        tilt_int;
  logic               dist_l_in, dist_r_in;
  logic [31:0]        dist_l_sum, dist_r_sum;
  logic [31:0]        tilt_abs, leak_mag;
  logic [31:0]        acc_sum;
  logic [35:0]        blend_v, blend_mag;
  logic [14:0]        clamp_mag;
  logic [15:0]        right_val;
  logic [31:0]        seven_mag;
  logic [QW-1:0]      left_cap;
  logic [16:0]        left_mag;
  logic [15:0]        left_val;

  // ---------------------------------------------------------------------------
  // configuration port: write on the access phase, pready tied high
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_zero_r     <= 16'd0;
      angle_gain_r    <= 24'd0;
      rate_gain_r     <= 24'd0;
      distance_gain_r <= 24'd0;
      speed_gain_r    <= 24'd0;
      encoder_scale_r <= 24'd65536;
      tick_seconds_r  <= 16'd655;
      speed_limit_r   <= 15'd300;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GYRO_ZERO:     gyro_zero_r     <= cfg_pwdata[15:0];
        REG_ANGLE_GAIN:    angle_gain_r    <= cfg_pwdata[23:0];
        REG_RATE_GAIN:     rate_gain_r     <= cfg_pwdata[23:0];
        REG_DISTANCE_GAIN: distance_gain_r <= cfg_pwdata[23:0];
        REG_SPEED_GAIN:    speed_gain_r    <= cfg_pwdata[23:0];
        REG_ENCODER_SCALE: encoder_scale_r <= cfg_pwdata[23:0];
        REG_TICK_SECONDS:  tick_seconds_r  <= cfg_pwdata[15:0];
        REG_SPEED_LIMIT:   speed_limit_r   <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GYRO_ZERO:     cfg_prdata = {16'd0, gyro_zero_r};
      REG_ANGLE_GAIN:    cfg_prdata = {8'd0, angle_gain_r};
      REG_RATE_GAIN:     cfg_prdata = {8'd0, rate_gain_r};
      REG_DISTANCE_GAIN: cfg_prdata = {8'd0, distance_gain_r};
      REG_SPEED_GAIN:    cfg_prdata = {8'd0, speed_gain_r};
      REG_ENCODER_SCALE: cfg_prdata = {8'd0, encoder_scale_r};
      REG_TICK_SECONDS:  cfg_prdata = {16'd0, tick_seconds_r};
      REG_SPEED_LIMIT:   cfg_prdata = {17'd0, speed_limit_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared multiplier
  // ---------------------------------------------------------------------------
  tbsf_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // ---------------------------------------------------------------------------
  // datapath around the multiplier
  // ---------------------------------------------------------------------------
  // gyro offset removal, sign and magnitude for the divide by 1800
  assign gyro_diff = $signed({raw_r[15], raw_r}) - $signed({gyro_zero_r[15], gyro_zero_r});
  assign gyro_mag  = gyro_diff[16] ? 16'(-gyro_diff) : gyro_diff[15:0];

  // one remainder compare shared by all four constant divisions
  always_comb begin
    case (step_r)
      SP_GYRO_END: div_cur = GYRO_DIV;
      SP_LEAK_END: div_cur = LEAK_DIV;
      SP_BL_END:   div_cur = BLEND_DIV;
      SP_LEFT_END: div_cur = LEFT_DIV;
      default:     div_cur = LEAK_DIV;
    endcase
  end

  assign rem      = x_r - prod[31:0];
  assign fixed_q  = q_r + {{(QW-1){1'b0}}, (rem >= div_cur)};
  assign rate_val = rsign_r ? 23'(-fixed_q[22:0]) : fixed_q[22:0];

  // means, rounded toward zero
  assign spd_sum = {speed_l_r[31], speed_l_r} + {speed_r_r[31], speed_r_r};
  assign spd_adj = spd_sum + {32'd0, spd_sum[32]};
  assign mean_s  = spd_adj[32:1];
  assign dst_sum = {dist_l_r[31], dist_l_r} + {dist_r_r[31], dist_r_r};
  assign dst_adj = dst_sum + {32'd0, dst_sum[32]};
  assign mean_d  = dst_adj[32:1];

  // tilt integration and distance accumulation
  assign tilt_int   = sat32(sx32(tilt_r) + q16_trunc(prod));
  assign dist_l_in  = ($signed(dist_l_r) < DIST_BOUND) && ($signed(dist_l_r) > -DIST_BOUND);
  assign dist_r_in  = ($signed(dist_r_r) < DIST_BOUND) && ($signed(dist_r_r) > -DIST_BOUND);
  assign dist_l_sum = sat32(sx32(dist_l_r) + sx32(speed_l_r));
  assign dist_r_sum = sat32(sx32(dist_r_r) + sx32(speed_r_r));

  // leak: |t|*999/1000 = |t| - ceil(|t|/1000)
  assign tilt_abs = tilt_r[31] ? 32'(-tilt_r) : tilt_r;
  assign leak_mag = x_r - (LEAK_DIV - 32'd1) - {{(32-QW){1'b0}}, fixed_q};

  // weighted sum and blend
  assign acc_sum   = sat32(q16_trunc({{(PROD_W-ACC_W){acc_r[ACC_W-1]}}, acc_r}));
  assign blend_v   = {{4{prev_r[31]}}, prev_r} + {sum_r[31], sum_r, 3'b000}
                   + {{4{sum_r[31]}}, sum_r};
  assign blend_mag = blend_v[35] ? 36'(-blend_v) : blend_v;

  // clamp and drives
  assign clamp_mag = (fixed_q > {{(QW-15){1'b0}}, speed_limit_r}) ? speed_limit_r
                                                                  : fixed_q[14:0];
  assign right_val = bsign_r ? 16'(-{1'b0, clamp_mag}) : {1'b0, clamp_mag};
  assign seven_mag = {14'd0, clamp_mag, 3'b000} - {17'd0, clamp_mag};
  assign left_cap  = bsign_r ? QW'(32768) : QW'(32767);
  assign left_mag  = (fixed_q > left_cap) ? left_cap[16:0] : fixed_q[16:0];
  assign left_val  = bsign_r ? 16'(-left_mag) : left_mag[15:0];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    raw_nxt        = raw_r;
    lcnt_nxt       = lcnt_r;
    rcnt_nxt       = rcnt_r;
    x_nxt          = x_r;
    q_nxt          = q_r;
    rsign_nxt      = rsign_r;
    tsign_nxt      = tsign_r;
    bsign_nxt      = bsign_r;
    rate_nxt       = rate_r;
    speed_l_nxt    = speed_l_r;
    speed_r_nxt    = speed_r_r;
    tilt_nxt       = tilt_r;
    dist_l_nxt     = dist_l_r;
    dist_r_nxt     = dist_r_r;
    prev_nxt       = prev_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    right_hold_nxt = right_hold_r;
    right_nxt      = right_r;
    left_nxt       = left_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    mul_req        = '0;

    if (state_r == ST_IDLE) begin
      if (in_tvalid) begin
        raw_nxt   = in_tdata[15:0];
        lcnt_nxt  = in_tdata[31:16];
        rcnt_nxt  = in_tdata[47:32];
        acc_nxt   = '0;
        step_nxt  = SP_GYRO_MUL;
        state_nxt = ST_RUN;
      end
    end else begin
      step_nxt = step_r + 5'd1;
      case (step_r)
        SP_GYRO_MUL: begin
          x_nxt      = {3'd0, gyro_mag, 13'd0};
          rsign_nxt  = gyro_diff[16];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-29){1'b0}}, gyro_mag, 13'd0};
          mul_req.b  = {{(MUL_W-32){1'b0}}, GYRO_RECIP};
        end
        SP_GYRO_FIX: begin
          q_nxt      = prod[GYRO_SHIFT +: QW];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-QW){1'b0}}, prod[GYRO_SHIFT +: QW]};
          mul_req.b  = {{(MUL_W-32){1'b0}}, GYRO_DIV};
        end
        SP_GYRO_END: begin
          rate_nxt   = rate_val;
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-16){lcnt_r[15]}}, lcnt_r};
          mul_req.b  = {{(MUL_W-24){1'b0}}, encoder_scale_r};
        end
        SP_SPD_L: begin
          speed_l_nxt = sat32(prod);
          mul_req.en  = 1'b1;
          mul_req.a   = {{(MUL_W-16){rcnt_r[15]}}, rcnt_r};
          mul_req.b   = {{(MUL_W-24){1'b0}}, encoder_scale_r};
        end
        SP_SPD_R: begin
          speed_r_nxt = sat32(prod);
          mul_req.en  = 1'b1;
          mul_req.a   = {{(MUL_W-23){rate_r[22]}}, rate_r};
          mul_req.b   = {{(MUL_W-16){1'b0}}, tick_seconds_r};
        end
        SP_TILT_INT: begin
          tilt_nxt = tilt_int;
          if (dist_l_in) begin
            dist_l_nxt = dist_l_sum;
          end
          if (dist_r_in) begin
            dist_r_nxt = dist_r_sum;
          end
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-24){speed_gain_r[23]}}, speed_gain_r};
          mul_req.b  = {{(MUL_W-32){mean_s[31]}}, mean_s};
        end
        SP_ACC_SPD: begin
          acc_nxt    = acc_r + prod[ACC_W-1:0];
          x_nxt      = tilt_abs + (LEAK_DIV - 32'd1);
          tsign_nxt  = tilt_r[31];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-24){distance_gain_r[23]}}, distance_gain_r};
          mul_req.b  = {{(MUL_W-32){mean_d[31]}}, mean_d};
        end
        SP_LEAK_MUL: begin
          acc_nxt    = acc_r + prod[ACC_W-1:0];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-32){1'b0}}, x_r};
          mul_req.b  = {{(MUL_W-32){1'b0}}, LEAK_RECIP};
        end
        SP_LEAK_FIX: begin
          q_nxt      = prod[LEAK_SHIFT +: QW];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-QW){1'b0}}, prod[LEAK_SHIFT +: QW]};
          mul_req.b  = {{(MUL_W-32){1'b0}}, LEAK_DIV};
        end
        SP_LEAK_END: begin
          tilt_nxt   = tsign_r ? 32'(-leak_mag) : leak_mag;
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-24){rate_gain_r[23]}}, rate_gain_r};
          mul_req.b  = {{(MUL_W-23){rate_r[22]}}, rate_r};
        end
        SP_ACC_RATE: begin
          acc_nxt    = acc_r + prod[ACC_W-1:0];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-24){angle_gain_r[23]}}, angle_gain_r};
          mul_req.b  = {{(MUL_W-32){tilt_r[31]}}, tilt_r};
        end
        SP_ACC_ANG: begin
          acc_nxt = acc_r + prod[ACC_W-1:0];
        end
        SP_SUM: begin
          sum_nxt = acc_sum;
        end
        SP_BLEND: begin
          // only whole units survive the divide by 10*2^16
          x_nxt     = {12'd0, blend_mag[35:16]};
          bsign_nxt = blend_v[35];
          prev_nxt  = sum_r;
        end
        SP_BL_MUL: begin
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-32){1'b0}}, x_r};
          mul_req.b  = {{(MUL_W-32){1'b0}}, BLEND_RECIP};
        end
        SP_BL_FIX: begin
          q_nxt      = prod[BLEND_SHIFT +: QW];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-QW){1'b0}}, prod[BLEND_SHIFT +: QW]};
          mul_req.b  = {{(MUL_W-32){1'b0}}, BLEND_DIV};
        end
        SP_BL_END: begin
          right_hold_nxt = right_val;
          x_nxt          = seven_mag;
        end
        SP_LEFT_MUL: begin
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-32){1'b0}}, x_r};
          mul_req.b  = {{(MUL_W-32){1'b0}}, LEFT_RECIP};
        end
        SP_LEFT_FIX: begin
          q_nxt      = prod[LEFT_SHIFT +: QW];
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_W-QW){1'b0}}, prod[LEFT_SHIFT +: QW]};
          mul_req.b  = {{(MUL_W-32){1'b0}}, LEFT_DIV};
        end
        SP_LEFT_END: begin
          // wait here while the previous result is still unclaimed
          if (!out_valid_r || out_tready) begin
            right_nxt     = right_hold_r;
            left_nxt      = left_val;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            step_nxt = step_r;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_GYRO_MUL;
      out_valid_r <= 1'b0;
      tilt_r      <= 32'd0;
      dist_l_r    <= 32'd0;
      dist_r_r    <= 32'd0;
      prev_r      <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      tilt_r      <= tilt_nxt;
      dist_l_r    <= dist_l_nxt;
      dist_r_r    <= dist_r_nxt;
      prev_r      <= prev_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    raw_r        <= raw_nxt;
    lcnt_r       <= lcnt_nxt;
    rcnt_r       <= rcnt_nxt;
    x_r          <= x_nxt;
    q_r          <= q_nxt;
    rsign_r      <= rsign_nxt;
    tsign_r      <= tsign_nxt;
    bsign_r      <= bsign_nxt;
    rate_r       <= rate_nxt;
    speed_l_r    <= speed_l_nxt;
    speed_r_r    <= speed_r_nxt;
    sum_r        <= sum_nxt;
    acc_r        <= acc_nxt;
    right_hold_r <= right_hold_nxt;
    right_r      <= right_nxt;
    left_r       <= left_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {left_r, right_r};

endmodule

/* src/tbsf_checker.sv */
module tbsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed or dropped while stalled");

  // one tick at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready again right after accepting a tick");

  // left drive follows right drive in sign and in zero
  a_drive_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15] == out_tdata[31]) &&
                   ((out_tdata[15:0] == 16'd0) == (out_tdata[31:16] == 16'd0)))
    else $error("left and right drive disagree in sign");

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind tilt_balance_state_feedback tbsf_checker u_tbsf_checker (.*);
